/* design/deq_pkg.sv */
package deq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_LIST       = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_LISTED = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

endpackage

/* design/deq_mem.sv */
module deq_mem #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_wdata,
    input  logic                              i_re,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [deq_pkg::VALUE_W-1:0] o_rdata
);

    logic signed [deq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [deq_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/double_ended_queue_top.sv */
// Bounded double-ended queue of DEPTH signed 32-bit values in a circular
// single-port-write, single-port-read memory with a registered read port.
// A push, or any operation that finds the queue empty or full, is accepted
// and its result appears in the next cycle. A pop first reads the memory,
// then presents the result from S_READ once the output is not stalled. A
// listing walks the store from front to rear through the single read port,
// giving one result per stored value. Only one transaction is in work at a
// time; input stall is high while an operation is in work or while the
// output register holds a result that is being stalled. Unused mode codes
// are accepted and ignored. The store needs no clearing after reset.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic signed [deq_pkg::VALUE_W-1:0] o_value_res,
    output logic                              o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LIST
    } t_state;

    t_state                             r_state, n_state;
    logic [AW-1:0]                      r_head, n_head;
    logic [OW-1:0]                      r_occ, n_occ;
    logic [OW-1:0]                      r_idx, n_idx;
    logic                               r_ovalid, n_ovalid;
    deq_pkg::t_status                   r_status, n_status;
    logic signed [deq_pkg::VALUE_W-1:0] r_value, n_value;
    logic                               r_last, n_last;

    logic                               out_ready;
    logic                               acc;
    logic                               mem_we;
    logic                               mem_re;
    logic [AW-1:0]                      mem_waddr;
    logic [AW-1:0]                      mem_raddr;
    logic signed [deq_pkg::VALUE_W-1:0] mem_rdata;
    logic [AW-1:0]                      head_inc;
    logic [AW-1:0]                      head_dec;
    logic                               list_end;

    function automatic logic [AW-1:0] f_slot(logic [AW-1:0] h, logic [OW-1:0] off);
        logic [OW:0] s;
        s = {{(OW + 1 - AW){1'b0}}, h} + {1'b0, off};
        if (s >= (OW + 1)'(DEPTH)) begin
            s = s - (OW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign out_ready = !r_ovalid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !out_ready;
    assign acc       = i_valid && !o_stall;
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign list_end  = (OW'(r_idx + 1'b1) == r_occ);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_ovalid  = r_ovalid && i_stall;
        n_status  = r_status;
        n_value   = r_value;
        n_last    = r_last;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_head;
        mem_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (deq_pkg::t_mode'(i_mode))
                        deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
                            n_ovalid = 1'b1;
                            n_last   = 1'b1;
                            if (r_occ == OW'(DEPTH)) begin
                                n_status = deq_pkg::ST_FULL;
                                n_value  = '0;
                            end else begin
                                mem_we   = 1'b1;
                                n_occ    = r_occ + 1'b1;
                                n_status = deq_pkg::ST_PUSHED;
                                n_value  = i_value;
                                if (deq_pkg::t_mode'(i_mode) == deq_pkg::MODE_PUSH_FRONT) begin
                                    mem_waddr = head_dec;
                                    n_head    = head_dec;
                                end else begin
                                    mem_waddr = f_slot(r_head, r_occ);
                                end
                            end
                        end
                        deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
                            if (r_occ == '0) begin
                                n_ovalid = 1'b1;
                                n_last   = 1'b1;
                                n_status = deq_pkg::ST_EMPTY;
                                n_value  = '0;
                            end else begin
                                mem_re  = 1'b1;
                                n_occ   = r_occ - 1'b1;
                                n_state = S_READ;
                                if (deq_pkg::t_mode'(i_mode) == deq_pkg::MODE_POP_FRONT) begin
                                    mem_raddr = r_head;
                                    n_head    = head_inc;
                                end else begin
                                    mem_raddr = f_slot(r_head, r_occ - 1'b1);
                                end
                            end
                        end
                        deq_pkg::MODE_LIST: begin
                            if (r_occ == '0) begin
                                n_ovalid = 1'b1;
                                n_last   = 1'b1;
                                n_status = deq_pkg::ST_EMPTY;
                                n_value  = '0;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_idx     = '0;
                                n_state   = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_ready) begin
                    n_ovalid = 1'b1;
                    n_last   = 1'b1;
                    n_status = deq_pkg::ST_POPPED;
                    n_value  = mem_rdata;
                    n_state  = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_ready) begin
                    n_ovalid = 1'b1;
                    n_last   = list_end;
                    n_status = deq_pkg::ST_LISTED;
                    n_value  = mem_rdata;
                    if (list_end) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = f_slot(r_head, OW'(r_idx + 1'b1));
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    deq_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_value),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_valid     = r_ovalid;
    assign o_status    = r_status;
    assign o_value_res = r_value;
    assign o_last      = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_mode == deq_pkg::MODE_POP_FRONT || i_mode == deq_pkg::MODE_POP_REAR)
        && r_occ != '0 |=> r_state == S_READ)
        else $error("pop did not start a read");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIST |-> r_occ != '0 && r_idx < r_occ)
        else $error("listing walked past the stored values");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ && out_ready |=> o_valid && o_last
        && o_status == deq_pkg::ST_POPPED)
        else $error("pop result not presented");

endmodule

/* dv/tb_double_ended_queue_top.sv */
`timescale 1ns / 100ps

module tb_double_ended_queue_top;

    localparam int DEPTH          = deq_pkg::DEPTH_DEF;
    localparam int VW             = deq_pkg::VALUE_W;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int TOTAL_OPS      = 320;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = DEPTH + 8;
    localparam int MAX_PRINTS     = 50;

    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [2:0]           mode;
        logic signed [VW-1:0] value;
        bit                   wait_drain;
    } t_deq_op;

    typedef struct {
        deq_pkg::t_status     status;
        logic signed [VW-1:0] value;
        logic                 last;
    } t_deq_result;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [2:0]           i_mode  = 3'd0;
    logic signed [VW-1:0] i_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [2:0]           o_status;
    logic signed [VW-1:0] o_value_res;
    logic                 o_last;

    t_deq_op     pending_ops[$];
    t_deq_result exp_results[$];

    // shadow copy of the deque contents
    logic signed [VW-1:0] mdl_store[DEPTH];
    int                   mdl_head  = 0;
    int                   mdl_count = 0;

    int          plan_count = 0;
    int          planned_ops = 0;
    int          ops_sent   = 0;
    int          results_checked = 0;
    int          err_count  = 0;
    int          cnt_pushed = 0;
    int          cnt_popped = 0;
    int          cnt_listed = 0;
    int          cnt_empty  = 0;
    int          cnt_full   = 0;
    int          tx_gap     = 0;
    int          rx_hold    = 0;
    int          idle_cycles = 0;
    logic [31:0] cycle_no   = '0;

    double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_value_res(o_value_res),
        .o_last     (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic int gap_len(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return -1;
            2: return VAL_MAX;
            3: return VAL_MIN;
            default: return $urandom;
        endcase
    endfunction

    // updates the shadow deque and queues the results one transaction causes
    function automatic void deque_predict(input logic [2:0] mode,
                                          input logic signed [VW-1:0] value);
        logic signed [VW-1:0] v;
        case (mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
                if (mdl_count >= DEPTH) begin
                    exp_results.push_back('{deq_pkg::ST_FULL, '0, 1'b1});
                end else begin
                    if (mode == deq_pkg::MODE_PUSH_FRONT) begin
                        mdl_head = (mdl_head + DEPTH - 1) % DEPTH;
                        mdl_store[mdl_head] = value;
                    end else begin
                        mdl_store[(mdl_head + mdl_count) % DEPTH] = value;
                    end
                    mdl_count++;
                    exp_results.push_back('{deq_pkg::ST_PUSHED, value, 1'b1});
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
                if (mdl_count == 0) begin
                    exp_results.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
                end else begin
                    if (mode == deq_pkg::MODE_POP_FRONT) begin
                        v = mdl_store[mdl_head];
                        mdl_head = (mdl_head + 1) % DEPTH;
                    end else begin
                        v = mdl_store[(mdl_head + mdl_count - 1) % DEPTH];
                    end
                    mdl_count--;
                    exp_results.push_back('{deq_pkg::ST_POPPED, v, 1'b1});
                end
            end
            deq_pkg::MODE_LIST: begin
                if (mdl_count == 0) begin
                    exp_results.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
                end else begin
                    for (int k = 0; k < mdl_count; k++) begin
                        exp_results.push_back('{deq_pkg::ST_LISTED,
                                                mdl_store[(mdl_head + k) % DEPTH],
                                                (k == mdl_count - 1)});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic add_op(input logic [2:0] mode, input logic signed [VW-1:0] value,
                          input bit wait_drain);
        pending_ops.push_back('{mode, value, wait_drain});
        planned_ops++;
        case (mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
                if (plan_count < DEPTH) plan_count++;
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
                if (plan_count > 0) plan_count--;
            end
            default: ;
        endcase
    endtask

    function automatic logic [2:0] push_side();
        return $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_REAR;
    endfunction

    function automatic logic [2:0] pop_side();
        return $urandom_range(0, 1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_REAR;
    endfunction

    function automatic logic [2:0] unused_mode();
        case ($urandom_range(0, 2))
            0: return MODE_RSVD_5;
            1: return MODE_RSVD_6;
            default: return MODE_RSVD_7;
        endcase
    endfunction

    task automatic fill_sequence(input bit first);
        int extra;
        extra = $urandom_range(1, 2);
        while (plan_count < DEPTH) begin
            add_op(push_side(), rand_value(), first);
            first = 1'b0;
        end
        repeat (extra) begin
            add_op(push_side(), rand_value(), 1'b0);
        end
        add_op(deq_pkg::MODE_LIST, rand_value(), 1'b0);
    endtask

    task automatic drain_sequence();
        while (plan_count > 0) begin
            add_op(pop_side(), rand_value(), 1'b0);
        end
        add_op(pop_side(), rand_value(), 1'b0);
        add_op(deq_pkg::MODE_LIST, rand_value(), 1'b0);
    endtask

    task automatic mixed_sequence();
        int n;
        int p;
        n = $urandom_range(4, 12);
        repeat (n) begin
            p = $urandom_range(0, 99);
            if (p < 35) begin
                add_op(push_side(), rand_value(), $urandom_range(0, 29) == 0);
            end else if (p < 65) begin
                add_op(pop_side(), rand_value(), $urandom_range(0, 29) == 0);
            end else if (p < 80) begin
                add_op(deq_pkg::MODE_LIST, rand_value(), 1'b0);
            end else if (p < 85) begin
                add_op(unused_mode(), rand_value(), 1'b0);
            end else begin
                add_op(push_side(), rand_value(), 1'b0);
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        logic                 nxt_valid;
        logic [2:0]           nxt_mode;
        logic signed [VW-1:0] nxt_value;
        t_deq_op              op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            nxt_mode  = i_mode;
            nxt_value = i_value;
            if (i_valid && !o_stall) begin
                deque_predict(i_mode, i_value);
                ops_sent++;
                nxt_valid = 1'b0;
                tx_gap    = gap_len(cycle_no[8:7] == 2'b11);
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].wait_drain && exp_results.size() > 0)) begin
                    op        = pending_ops.pop_front();
                    nxt_valid = 1'b1;
                    nxt_mode  = op.mode;
                    nxt_value = op.value;
                end
            end
            i_valid <= nxt_valid;
            i_mode  <= nxt_mode;
            i_value <= nxt_value;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_deq_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_checked++;
                if (exp_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                              o_status, o_value_res, o_last));
                end else begin
                    want = exp_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    end
                    if (o_value_res !== want.value) begin
                        report_mismatch($sformatf("value got %0d want %0d",
                                                  o_value_res, want.value));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  o_last, want.last));
                    end
                end
                case (o_status)
                    deq_pkg::ST_PUSHED: cnt_pushed++;
                    deq_pkg::ST_POPPED: cnt_popped++;
                    deq_pkg::ST_LISTED: cnt_listed++;
                    deq_pkg::ST_EMPTY:  cnt_empty++;
                    deq_pkg::ST_FULL:   cnt_full++;
                    default: ;
                endcase
                // long hold-off so the block backs up into its input
                if (results_checked == 60 || results_checked == 500) begin
                    rx_hold = HOLD_CYCLES;
                end else begin
                    rx_hold = gap_len(cycle_no[9:8] == 2'b10);
                end
            end else if (rx_hold > 0) begin
                rx_hold--;
            end else if (cycle_no[9:8] != 2'b10 && $urandom_range(0, 7) == 0) begin
                rx_hold = $urandom_range(1, 4);
            end
            i_stall <= (rx_hold > 0);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int kind;

        // empty cases, unused modes, value extremes, both ends
        add_op(deq_pkg::MODE_POP_FRONT,  rand_value(), 1'b0);
        add_op(deq_pkg::MODE_POP_REAR,   rand_value(), 1'b0);
        add_op(deq_pkg::MODE_LIST,       rand_value(), 1'b0);
        add_op(MODE_RSVD_5,              VAL_MAX,      1'b0);
        add_op(MODE_RSVD_6,              VAL_MIN,      1'b0);
        add_op(MODE_RSVD_7,              -1,           1'b0);
        add_op(deq_pkg::MODE_PUSH_FRONT, VAL_MAX,      1'b0);
        add_op(deq_pkg::MODE_PUSH_REAR,  VAL_MIN,      1'b0);
        add_op(deq_pkg::MODE_PUSH_FRONT, '0,           1'b0);
        add_op(deq_pkg::MODE_PUSH_REAR,  -1,           1'b0);
        add_op(deq_pkg::MODE_LIST,       '0,           1'b0);
        add_op(deq_pkg::MODE_POP_FRONT,  '0,           1'b0);
        add_op(deq_pkg::MODE_POP_REAR,   '0,           1'b0);
        add_op(deq_pkg::MODE_LIST,       '0,           1'b0);
        add_op(deq_pkg::MODE_POP_REAR,   VAL_MAX,      1'b0);
        add_op(deq_pkg::MODE_POP_FRONT,  VAL_MIN,      1'b0);
        add_op(deq_pkg::MODE_POP_FRONT,  '0,           1'b0);
        add_op(deq_pkg::MODE_PUSH_REAR,  32'sh5A5A_5A5A, 1'b0);
        add_op(deq_pkg::MODE_PUSH_FRONT, 32'shA5A5_A5A5, 1'b0);
        add_op(deq_pkg::MODE_POP_REAR,   '0,           1'b0);
        add_op(deq_pkg::MODE_POP_REAR,   '0,           1'b0);
        add_op(deq_pkg::MODE_LIST,       '0,           1'b0);

        // first random sequence runs into the full bound after a full drain
        fill_sequence(1'b1);
        while (planned_ops < TOTAL_OPS) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                fill_sequence(1'b0);
            end else if (kind < 4) begin
                drain_sequence();
            end else if (kind < 9) begin
                mixed_sequence();
            end else begin
                repeat ($urandom_range(1, 3)) add_op(unused_mode(), rand_value(), 1'b0);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_ops.size() > 0 || i_valid || exp_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (exp_results.size() > 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      exp_results.size()));
        end
        $display("ran %0d transactions in, checked %0d results out", ops_sent, results_checked);
        $display("results: pushed %0d popped %0d listed %0d empty %0d full %0d, errors %0d",
                 cnt_pushed, cnt_popped, cnt_listed, cnt_empty, cnt_full, err_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
